[sv/npg_pkg.sv]
// ----------------------------------------------------------------------------
// npg_pkg
// Shared types and constants of the note-preview gate.
// ----------------------------------------------------------------------------
package npg_pkg;

  localparam int MAX_NOTES_DEFAULT = 16;

  localparam logic [18:0] RATE_SPS_RESET = 19'd44100;
  localparam logic [15:0] FULL_LEVEL = 16'd32768;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  localparam logic [1:0] KIND_NOTE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_EOS  = 2'd2;

  typedef enum logic [2:0] {
    MODE_WAIT   = 3'd0,
    MODE_START  = 3'd1,
    MODE_CHANGE = 3'd2,
    MODE_ACTIVE = 3'd3,
    MODE_END    = 3'd4,
    MODE_FLUSH  = 3'd5,
    MODE_EOS    = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OFF,
    ST_ON,
    ST_DONE,
    ST_EOS
  } ctrl_state_t;

  typedef struct packed {
    logic  slot_free;
    logic  active_empty;
    logic  queued_empty;
    logic  active_last;
    logic  queued_last;
    mode_t mode;
  } npg_status_t;

  typedef struct packed {
    logic start_item;
    logic end_req;
    logic read_begin;
    logic emit_off;
    logic emit_on;
    logic emit_done;
    logic emit_eos;
  } npg_cmd_t;

endpackage

[sv/note_preview_gate_unit.sv]
// A start or end transaction updates the gate's registers when it is accepted.
// A block read gives one result per cycle while the output is not stalled: as
// the mode asks, one off per sounding note, one on per queued note, then block
// done, or only end of stream; input ready is low until the last result is loaded.
// Reset clears mode to end of stream, the hold counter to no timeout and both lists.
// ----------------------------------------------------------------------------
// note_preview_gate_unit
// Note-preview gate: queues a chord, sounds it on block reads and times it out.
// ----------------------------------------------------------------------------
module note_preview_gate_unit #(
  parameter int MAX_NOTES = npg_pkg::MAX_NOTES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [18:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [15:0]        block_samples,
  input  logic [6:0]         pitch,
  input  logic               has_pitch,
  input  logic               first_item,
  input  logic               last_item,
  input  logic signed [31:0] timeout,
  input  logic [15:0]        level,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [6:0]         note_pitch,
  output logic [15:0]        note_volume,
  output logic [15:0]        done_samples,
  output logic               final_res
);
  import npg_pkg::*;

  npg_status_t status;
  npg_cmd_t    ctrl;

  npg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status),
    .ctrl     (ctrl)
  );

  npg_datapath #(
    .MAX_NOTES (MAX_NOTES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .block_samples (block_samples),
    .pitch         (pitch),
    .has_pitch     (has_pitch),
    .first_item    (first_item),
    .last_item     (last_item),
    .timeout       (timeout),
    .level         (level),
    .ctrl          (ctrl),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .note_pitch    (note_pitch),
    .note_volume   (note_volume),
    .done_samples  (done_samples),
    .final_res     (final_res)
  );

endmodule

[sv/npg_ctrl.sv]
// ----------------------------------------------------------------------------
// npg_ctrl
// Sequencer that accepts commands and walks the note lists of a block read.
// ----------------------------------------------------------------------------
module npg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          cmd,
  input  npg_pkg::npg_status_t status,
  output npg_pkg::npg_cmd_t    ctrl
);
  import npg_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && cmd == CMD_READ) begin
          case (status.mode)
            MODE_EOS: state_next = ST_EOS;
            MODE_START: state_next = status.queued_empty ? ST_DONE : ST_ON;
            MODE_CHANGE: begin
              if (!status.active_empty) begin
                state_next = ST_OFF;
              end else begin
                state_next = status.queued_empty ? ST_DONE : ST_ON;
              end
            end
            MODE_END: state_next = status.active_empty ? ST_DONE : ST_OFF;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_OFF: begin
        if (status.slot_free && status.active_last) begin
          if (status.mode == MODE_CHANGE && !status.queued_empty) begin
            state_next = ST_ON;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_ON: begin
        if (status.slot_free && status.queued_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE, ST_EOS: begin
        if (status.slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctrl = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctrl.start_item = in_valid && cmd == CMD_START;
        ctrl.end_req = in_valid && cmd == CMD_END;
        ctrl.read_begin = in_valid && cmd == CMD_READ;
      end
      ST_OFF: ctrl.emit_off = status.slot_free;
      ST_ON: ctrl.emit_on = status.slot_free;
      ST_DONE: ctrl.emit_done = status.slot_free;
      ST_EOS: ctrl.emit_eos = status.slot_free;
      default: ;
    endcase
  end

endmodule

[sv/npg_datapath.sv]
// ----------------------------------------------------------------------------
// npg_datapath
// Mode, hold counter, pitch lists and the output register of the gate.
// ----------------------------------------------------------------------------
module npg_datapath #(
  parameter int MAX_NOTES = npg_pkg::MAX_NOTES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [18:0]          cfg_wdata,
  input  logic [15:0]          block_samples,
  input  logic [6:0]           pitch,
  input  logic                 has_pitch,
  input  logic                 first_item,
  input  logic                 last_item,
  input  logic signed [31:0]   timeout,
  input  logic [15:0]          level,
  input  npg_pkg::npg_cmd_t     ctrl,
  output npg_pkg::npg_status_t  status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           kind,
  output logic [6:0]           note_pitch,
  output logic [15:0]          note_volume,
  output logic [15:0]          done_samples,
  output logic                 final_res
);
  import npg_pkg::*;

  localparam int CNT_W = $clog2(MAX_NOTES + 1);
  localparam int IDX_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NOTES);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  logic [18:0]        rate_sps;
  mode_t              mode_reg;
  mode_t              mode_next;
  logic signed [32:0] countdown;
  logic signed [32:0] countdown_next;
  logic [15:0]        note_level;
  logic [6:0]         queued_pitches [MAX_NOTES];
  logic [6:0]         active_pitches [MAX_NOTES];
  logic [CNT_W-1:0]   queued_count;
  logic [CNT_W-1:0]   active_count;
  logic [CNT_W-1:0]   idx;
  logic [15:0]        samples;

  logic [CNT_W-1:0]   queue_base;
  logic               do_append;
  logic               emit;
  logic               copy_done;
  mode_t              mode_mid;
  logic signed [32:0] count_mid;
  logic signed [32:0] count_sub;

  assign queue_base = first_item ? '0 : queued_count;
  assign do_append = ctrl.start_item && has_pitch && (queue_base < CNT_MAX);
  assign emit = ctrl.emit_off || ctrl.emit_on || ctrl.emit_done || ctrl.emit_eos;
  assign copy_done = ctrl.emit_done && (mode_reg == MODE_START || mode_reg == MODE_CHANGE);

  assign status.slot_free = !out_valid || out_ready;
  assign status.active_empty = active_count == '0;
  assign status.queued_empty = queued_count == '0;
  assign status.active_last = (idx + CNT_ONE) == active_count;
  assign status.queued_last = (idx + CNT_ONE) == queued_count;
  assign status.mode = mode_reg;

  always_comb begin
    mode_mid = mode_reg;
    count_mid = countdown;
    case (mode_reg)
      MODE_START, MODE_CHANGE: mode_mid = MODE_ACTIVE;
      MODE_END: begin
        mode_mid = MODE_FLUSH;
        count_mid = {13'd0, rate_sps, 1'b0};
      end
      default: ;
    endcase
    count_sub = count_mid - $signed({17'd0, samples});
    mode_next = mode_mid;
    countdown_next = count_mid;
    if (!count_mid[32]) begin
      countdown_next = count_sub;
      if (count_sub[32]) begin
        if (mode_mid == MODE_ACTIVE) begin
          mode_next = MODE_END;
        end else if (mode_mid == MODE_FLUSH) begin
          mode_next = MODE_EOS;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_sps <= RATE_SPS_RESET;
      mode_reg <= MODE_EOS;
      countdown <= '1;
      note_level <= FULL_LEVEL;
      queued_count <= '0;
      active_count <= '0;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        rate_sps <= cfg_wdata;
      end
      if (ctrl.start_item) begin
        queued_count <= do_append ? queue_base + CNT_ONE : queue_base;
        if (last_item) begin
          countdown <= {timeout[31], timeout};
          note_level <= (level > FULL_LEVEL) ? FULL_LEVEL : level;
          case (mode_reg)
            MODE_WAIT, MODE_FLUSH, MODE_EOS: mode_reg <= MODE_START;
            MODE_END, MODE_ACTIVE, MODE_CHANGE: mode_reg <= MODE_CHANGE;
            default: ;
          endcase
        end
      end
      if (ctrl.end_req) begin
        case (mode_reg)
          MODE_START: mode_reg <= MODE_WAIT;
          MODE_ACTIVE, MODE_CHANGE: mode_reg <= MODE_END;
          default: ;
        endcase
      end
      if (ctrl.emit_done) begin
        mode_reg <= mode_next;
        countdown <= countdown_next;
      end
      if (copy_done) begin
        active_count <= queued_count;
      end
      if (ctrl.read_begin) begin
        idx <= '0;
      end else if (ctrl.emit_off) begin
        idx <= status.active_last ? '0 : idx + CNT_ONE;
      end else if (ctrl.emit_on) begin
        idx <= idx + CNT_ONE;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_append) begin
      queued_pitches[queue_base[IDX_W-1:0]] <= pitch;
    end
    if (ctrl.emit_on) begin
      active_pitches[idx[IDX_W-1:0]] <= queued_pitches[idx[IDX_W-1:0]];
    end
    if (ctrl.read_begin) begin
      samples <= block_samples;
    end
    if (emit) begin
      kind <= KIND_NOTE;
      note_pitch <= '0;
      note_volume <= '0;
      done_samples <= '0;
      final_res <= 1'b0;
      if (ctrl.emit_off) begin
        note_pitch <= active_pitches[idx[IDX_W-1:0]];
      end else if (ctrl.emit_on) begin
        note_pitch <= queued_pitches[idx[IDX_W-1:0]];
        note_volume <= note_level;
      end else if (ctrl.emit_done) begin
        kind <= KIND_DONE;
        done_samples <= samples;
        final_res <= 1'b1;
      end else begin
        kind <= KIND_EOS;
        final_res <= 1'b1;
      end
    end
  end

endmodule

[sv/npg_checker.sv]
// ----------------------------------------------------------------------------
// npg_checker
// Port-level checks of the note-preview gate, bound to the top level.
// ----------------------------------------------------------------------------
module npg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  cmd,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [6:0]  note_pitch,
  input logic [15:0] note_volume,
  input logic [15:0] done_samples,
  input logic        final_res
);
  import npg_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(note_pitch)
      && $stable(note_volume) && $stable(done_samples) && $stable(final_res))
    else $error("Stalled result changed.");

  a_final_marks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (final_res == (kind != KIND_NOTE)))
    else $error("Final flag does not match result kind.");

  a_note_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_NOTE |-> done_samples == '0 && note_volume <= FULL_LEVEL)
    else $error("Note event carries bad fields.");

  a_read_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd == CMD_READ |=> !in_ready)
    else $error("Input accepted while a read is in progress.");

endmodule

bind note_preview_gate_unit npg_checker u_npg_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .cmd          (cmd),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .kind         (kind),
  .note_pitch   (note_pitch),
  .note_volume  (note_volume),
  .done_samples (done_samples),
  .final_res    (final_res)
);
